### hw/rtl/alu8f_pkg.sv
// Opcode codes, result type and the single-pass ALU function for the 8-bit ALU.
// Self-contained; used by the top level and by the testbench.
`timescale 1ns / 1ps

package alu8f_pkg;

    typedef enum logic [3:0] {
        OP_ADC  = 4'd0,
        OP_SBC  = 4'd1,
        OP_RLC  = 4'd2,
        OP_RRC  = 4'd3,
        OP_RL   = 4'd4,
        OP_RR   = 4'd5,
        OP_AND  = 4'd6,
        OP_XOR  = 4'd7,
        OP_OR   = 4'd8,
        OP_CPL  = 4'd9,
        OP_SWAP = 4'd10,
        OP_SET  = 4'd11,
        OP_GET  = 4'd12,
        OP_SLA  = 4'd13,
        OP_SRA  = 4'd14,
        OP_SRL  = 4'd15
    } t_op;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] operand_a;
        logic [7:0] operand_b;
        logic       carry_in;
        logic [2:0] bit_index;
    } t_req;

    typedef struct packed {
        logic [7:0] result_byte;
        logic       zero_flag;
        logic       subtract_flag;
        logic       half_carry_flag;
        logic       carry_flag;
        logic [7:0] aux_byte;
    } t_res;

    function automatic t_res alu_compute(input t_req req);
        logic [8:0] sum;
        logic [4:0] sum_lo;
        logic [8:0] diff;
        logic [4:0] diff_lo;
        logic [7:0] r;
        logic [7:0] a;
        logic       sub;
        logic       hc;
        logic       cy;
        logic       aux_is_a;
        t_res       res;
        a        = req.operand_a;
        sum      = {1'b0, a} + {1'b0, req.operand_b} + {8'd0, req.carry_in};
        sum_lo   = {1'b0, a[3:0]} + {1'b0, req.operand_b[3:0]} + {4'd0, req.carry_in};
        diff     = {1'b0, a} - {1'b0, req.operand_b} - {8'd0, req.carry_in};
        diff_lo  = {1'b0, a[3:0]} - {1'b0, req.operand_b[3:0]} - {4'd0, req.carry_in};
        r        = 8'd0;
        sub      = 1'b0;
        hc       = 1'b0;
        cy       = 1'b0;
        aux_is_a = 1'b0;
        case (t_op'(req.req_type))
            OP_ADC: begin
                r  = sum[7:0];
                hc = sum_lo[4];
                cy = sum[8];
            end
            OP_SBC: begin
                r   = diff[7:0];
                sub = 1'b1;
                hc  = diff_lo[4];
                cy  = diff[8];
            end
            OP_RLC: begin
                r        = {a[6:0], a[7]};
                aux_is_a = 1'b1;
            end
            OP_RRC: begin
                r        = {a[0], a[7:1]};
                aux_is_a = 1'b1;
            end
            OP_RL: begin
                r        = {a[6:0], req.carry_in};
                aux_is_a = 1'b1;
            end
            OP_RR: begin
                r        = {req.carry_in, a[7:1]};
                aux_is_a = 1'b1;
            end
            OP_AND:  r = a & req.operand_b;
            OP_XOR:  r = a ^ req.operand_b;
            OP_OR:   r = a | req.operand_b;
            OP_CPL:  r = ~a;
            OP_SWAP: r = {a[3:0], a[7:4]};
            OP_SET: begin
                r                = a;
                r[req.bit_index] = |req.operand_b;
            end
            OP_GET: begin
                r        = {7'd0, a[req.bit_index]};
                aux_is_a = 1'b1;
            end
            OP_SLA: begin
                r        = {a[6:0], 1'b0};
                aux_is_a = 1'b1;
            end
            OP_SRA: begin
                r        = {a[7], a[7:1]};
                aux_is_a = 1'b1;
            end
            OP_SRL: begin
                r        = {1'b0, a[7:1]};
                aux_is_a = 1'b1;
            end
            default: r = 8'd0;
        endcase
        res.result_byte     = r;
        res.zero_flag       = (r == 8'd0);
        res.subtract_flag   = sub;
        res.half_carry_flag = hc;
        res.carry_flag      = cy;
        res.aux_byte        = aux_is_a ? a : r;
        return res;
    endfunction

endpackage

### hw/rtl/eight_bit_alu_with_flags.sv
// Stages: input register, then ALU logic, then result register.
// Throughput: one request per cycle while o_in_stall is low.
// Reset (synchronous, active low) empties both stages; no other state is kept.
// Input stall rises only when both stages hold requests and the output is stalled.
// Top level of the 8-bit ALU with flags; depends on alu8f_pkg.
`timescale 1ns / 1ps

module eight_bit_alu_with_flags (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [3:0] i_req_type,
    input  logic [7:0] i_operand_a,
    input  logic [7:0] i_operand_b,
    input  logic       i_carry_in,
    input  logic [2:0] i_bit_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_result_byte,
    output logic       o_zero_flag,
    output logic       o_subtract_flag,
    output logic       o_half_carry_flag,
    output logic       o_carry_flag,
    output logic [7:0] o_aux_byte
);

    logic              r_req_valid;
    alu8f_pkg::t_req   r_req;
    logic              r_res_valid;
    alu8f_pkg::t_res   r_res;
    alu8f_pkg::t_res   n_res;
    logic              res_load;
    logic              req_load;

    assign res_load   = !r_res_valid || !i_out_stall;
    assign req_load   = !r_req_valid || res_load;
    assign o_in_stall = !req_load;
    assign n_res      = alu8f_pkg::alu_compute(r_req);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            if (req_load) begin
                r_req_valid <= i_in_valid;
            end
            if (res_load) begin
                r_res_valid <= r_req_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (req_load && i_in_valid) begin
            r_req.req_type  <= i_req_type;
            r_req.operand_a <= i_operand_a;
            r_req.operand_b <= i_operand_b;
            r_req.carry_in  <= i_carry_in;
            r_req.bit_index <= i_bit_index;
        end
        if (res_load && r_req_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid       = r_res_valid;
    assign o_result_byte     = r_res.result_byte;
    assign o_zero_flag       = r_res.zero_flag;
    assign o_subtract_flag   = r_res.subtract_flag;
    assign o_half_carry_flag = r_res.half_carry_flag;
    assign o_carry_flag      = r_res.carry_flag;
    assign o_aux_byte        = r_res.aux_byte;

endmodule

### hw/rtl/alu8f_checker.sv
// Port-level checks for the 8-bit ALU, bound to eight_bit_alu_with_flags.
// Sees only the top-level ports.
`timescale 1ns / 1ps

module alu8f_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_result_byte,
    input logic       o_zero_flag,
    input logic       o_subtract_flag,
    input logic [7:0] o_aux_byte
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result_byte))
        else $error("result changed under stall");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_zero_flag == (o_result_byte == 8'd0)))
        else $error("zero flag mismatch");

    a_sbc_aux: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_subtract_flag |-> (o_aux_byte == o_result_byte))
        else $error("aux byte differs from result for subtract");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind eight_bit_alu_with_flags alu8f_checker u_alu8f_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_result_byte  (o_result_byte),
    .o_zero_flag    (o_zero_flag),
    .o_subtract_flag(o_subtract_flag),
    .o_aux_byte     (o_aux_byte)
);

### tb/sv/testbench.sv
// Self-checking testbench for the eight-bit ALU with flags: directed corner requests,
// then random requests with idle and stall bursts, checked against a local predictor.
// Depends on alu8f_pkg and eight_bit_alu_with_flags.
`timescale 1ns / 1ps

module testbench;

    localparam int STUCK_LIMIT   = 500;
    localparam int RANDOM_COUNT  = 600;
    localparam int QUIET_TAIL    = 100;
    localparam int REPORT_LIMIT  = 10;

    class alu_result_tracker;
        alu8f_pkg::t_res awaited_results[$];
        int   failures;

        function new();
            failures = 0;
        endfunction

        function alu8f_pkg::t_res compute_expected(alu8f_pkg::t_req req);
            int              a;
            int              b;
            int              c;
            int              idx;
            int              total;
            logic [7:0]      r;
            bit              echo_a;
            alu8f_pkg::t_res res;
            a      = int'(req.operand_a);
            b      = int'(req.operand_b);
            c      = int'(req.carry_in);
            idx    = int'(req.bit_index);
            res    = '0;
            echo_a = 1'b0;
            r      = 8'd0;
            case (alu8f_pkg::t_op'(req.req_type))
                alu8f_pkg::OP_ADC: begin
                    total               = a + b + c;
                    r                   = total[7:0];
                    res.half_carry_flag = ((a % 16) + (b % 16) + c) > 15;
                    res.carry_flag      = total > 255;
                end
                alu8f_pkg::OP_SBC: begin
                    total               = a - b - c;
                    r                   = total[7:0];
                    res.subtract_flag   = 1'b1;
                    res.half_carry_flag = (a % 16) < ((b % 16) + c);
                    res.carry_flag      = a < (b + c);
                end
                alu8f_pkg::OP_RLC: begin
                    r      = 8'((a << 1) | (a >> 7));
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_RRC: begin
                    r      = 8'((a >> 1) | ((a & 1) << 7));
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_RL: begin
                    r      = 8'((a << 1) | c);
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_RR: begin
                    r      = 8'((a >> 1) | (c << 7));
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_AND:  r = 8'(a & b);
                alu8f_pkg::OP_XOR:  r = 8'(a ^ b);
                alu8f_pkg::OP_OR:   r = 8'(a | b);
                alu8f_pkg::OP_CPL:  r = 8'(255 - a);
                alu8f_pkg::OP_SWAP: r = 8'((a % 16) * 16 + a / 16);
                alu8f_pkg::OP_SET:
                    r = 8'((b != 0) ? (a | (1 << idx)) : (a & ~(1 << idx)));
                alu8f_pkg::OP_GET: begin
                    r      = 8'((a >> idx) & 1);
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_SLA: begin
                    r      = 8'(a << 1);
                    echo_a = 1'b1;
                end
                alu8f_pkg::OP_SRA: begin
                    r      = 8'((a >> 1) | (a & 128));
                    echo_a = 1'b1;
                end
                default: begin
                    r      = 8'(a >> 1);
                    echo_a = 1'b1;
                end
            endcase
            res.result_byte = r;
            res.zero_flag   = (r == 8'd0);
            res.aux_byte    = echo_a ? req.operand_a : r;
            return res;
        endfunction

        function void note_request(alu8f_pkg::t_req req);
            awaited_results.push_back(compute_expected(req));
        endfunction

        function void check_result(alu8f_pkg::t_res got);
            alu8f_pkg::t_res want;
            if (awaited_results.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result with no request pending: res=%02h aux=%02h",
                             got.result_byte, got.aux_byte);
                return;
            end
            want = awaited_results.pop_front();
            if (got.result_byte !== want.result_byte || got.zero_flag !== want.zero_flag ||
                got.subtract_flag !== want.subtract_flag ||
                got.half_carry_flag !== want.half_carry_flag ||
                got.carry_flag !== want.carry_flag || got.aux_byte !== want.aux_byte) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: expected res=%02h z=%0b n=%0b h=%0b c=%0b aux=%02h, %s",
                             want.result_byte, want.zero_flag, want.subtract_flag,
                             want.half_carry_flag, want.carry_flag, want.aux_byte,
                             $sformatf("got res=%02h z=%0b n=%0b h=%0b c=%0b aux=%02h",
                                       got.result_byte, got.zero_flag, got.subtract_flag,
                                       got.half_carry_flag, got.carry_flag, got.aux_byte));
            end
        endfunction

        function int pending_count();
            return awaited_results.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [3:0] i_req_type;
    logic [7:0] i_operand_a;
    logic [7:0] i_operand_b;
    logic       i_carry_in;
    logic [2:0] i_bit_index;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [7:0] o_result_byte;
    logic       o_zero_flag;
    logic       o_subtract_flag;
    logic       o_half_carry_flag;
    logic       o_carry_flag;
    logic [7:0] o_aux_byte;

    alu_result_tracker tracker = new();
    bit bursts_allowed = 1'b1;
    bit feeding        = 1'b1;
    int stuck_cycles   = 0;

    eight_bit_alu_with_flags DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_req_type        (i_req_type),
        .i_operand_a       (i_operand_a),
        .i_operand_b       (i_operand_b),
        .i_carry_in        (i_carry_in),
        .i_bit_index       (i_bit_index),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_result_byte     (o_result_byte),
        .o_zero_flag       (o_zero_flag),
        .o_subtract_flag   (o_subtract_flag),
        .o_half_carry_flag (o_half_carry_flag),
        .o_carry_flag      (o_carry_flag),
        .o_aux_byte        (o_aux_byte)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // output back-pressure in short bursts
    initial begin
        int stall_len;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (bursts_allowed && $urandom_range(0, 5) == 0) begin
                stall_len = $urandom_range(1, 6);
                i_out_stall <= 1'b1;
                repeat (stall_len) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        bit              moved;
        alu8f_pkg::t_req req;
        alu8f_pkg::t_res got;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                got.result_byte     = o_result_byte;
                got.zero_flag       = o_zero_flag;
                got.subtract_flag   = o_subtract_flag;
                got.half_carry_flag = o_half_carry_flag;
                got.carry_flag      = o_carry_flag;
                got.aux_byte        = o_aux_byte;
                tracker.check_result(got);
                moved = 1'b1;
            end
            if (i_in_valid && !o_in_stall) begin
                req.req_type  = i_req_type;
                req.operand_a = i_operand_a;
                req.operand_b = i_operand_b;
                req.carry_in  = i_carry_in;
                req.bit_index = i_bit_index;
                tracker.note_request(req);
                moved = 1'b1;
            end
            if (moved || (!feeding && tracker.pending_count() == 0))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input alu8f_pkg::t_req req);
        int gap;
        if (bursts_allowed && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_req_type  <= req.req_type;
        i_operand_a <= req.operand_a;
        i_operand_b <= req.operand_b;
        i_carry_in  <= req.carry_in;
        i_bit_index <= req.bit_index;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic send_op(input alu8f_pkg::t_op op, input logic [7:0] a,
                           input logic [7:0] b, input logic c, input logic [2:0] idx);
        alu8f_pkg::t_req req;
        req.req_type  = op;
        req.operand_a = a;
        req.operand_b = b;
        req.carry_in  = c;
        req.bit_index = idx;
        send_request(req);
    endtask

    // corner bytes turn up often so nibble and byte boundaries are hit
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h0F;
            3: return 8'h80;
            4: return 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        alu8f_pkg::t_req req;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_req_type  = 4'd0;
        i_operand_a = 8'd0;
        i_operand_b = 8'd0;
        i_carry_in  = 1'b0;
        i_bit_index = 3'd0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_op(alu8f_pkg::OP_ADC,  8'hFF, 8'hFF, 1'b1, 3'd0);
        send_op(alu8f_pkg::OP_ADC,  8'h0F, 8'h01, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_ADC,  8'h00, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_ADC,  8'h80, 8'h80, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SBC,  8'h00, 8'h00, 1'b1, 3'd0);
        send_op(alu8f_pkg::OP_SBC,  8'h10, 8'h01, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SBC,  8'hFF, 8'hFF, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SBC,  8'h00, 8'hFF, 1'b1, 3'd0);
        send_op(alu8f_pkg::OP_RLC,  8'h80, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_RRC,  8'h01, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_RL,   8'h80, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_RR,   8'h01, 8'h00, 1'b1, 3'd0);
        send_op(alu8f_pkg::OP_AND,  8'hFF, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_XOR,  8'hA5, 8'hA5, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_OR,   8'h00, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_CPL,  8'hFF, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SWAP, 8'h5A, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SET,  8'h00, 8'h01, 1'b0, 3'd7);
        send_op(alu8f_pkg::OP_SET,  8'hFF, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SET,  8'h00, 8'h80, 1'b1, 3'd3);
        send_op(alu8f_pkg::OP_GET,  8'h80, 8'hFF, 1'b0, 3'd7);
        send_op(alu8f_pkg::OP_GET,  8'h7F, 8'hFF, 1'b1, 3'd7);
        send_op(alu8f_pkg::OP_SLA,  8'h80, 8'h00, 1'b1, 3'd0);
        send_op(alu8f_pkg::OP_SRA,  8'h80, 8'h00, 1'b0, 3'd0);
        send_op(alu8f_pkg::OP_SRL,  8'h01, 8'h00, 1'b1, 3'd0);

        for (int n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT - QUIET_TAIL)
                bursts_allowed = 1'b0;
            req.req_type  = 4'($urandom_range(0, 15));
            req.operand_a = pick_byte();
            req.operand_b = pick_byte();
            req.carry_in  = 1'($urandom_range(0, 1));
            req.bit_index = 3'($urandom_range(0, 7));
            if (alu8f_pkg::t_op'(req.req_type) == alu8f_pkg::OP_SET &&
                $urandom_range(0, 1) == 0)
                req.operand_b = 8'h00;
            send_request(req);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        feeding = 1'b0;

        while (tracker.pending_count() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (tracker.failures == 0 && tracker.pending_count() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
hw/rtl/alu8f_pkg.sv
hw/rtl/eight_bit_alu_with_flags.sv
hw/rtl/alu8f_checker.sv
tb/sv/testbench.sv
